FILE: hdl/least_loaded_session_assigner_macros.svh
// assertion macros used by the session assigner back end
`ifndef LEAST_LOADED_SESSION_ASSIGNER_MACROS_SVH
`define LEAST_LOADED_SESSION_ASSIGNER_MACROS_SVH

// same-cycle implication, checked out of reset
`define LLSA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define LLSA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/llsa_pkg.sv
// shared constants, types and entry format of the session assigner
package llsa_pkg;

	localparam int NUM_WORKERS = 16;
	localparam int COUNT_WIDTH = 16;

	localparam int ID_W      = 64;
	localparam int MIX_RIGHT = 33;
	localparam int MIX_LEFT  = 11;
	localparam int ACTIVE_W  = 5;
	localparam int RELEASE_W = 8;
	localparam int CHOSEN_W  = 4;
	localparam int LOAD_W    = 16;

	// worker index width and width of a worker count value (0..NUM_WORKERS)
	localparam int WIDX = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
	localparam int NW   = $clog2(NUM_WORKERS + 1);

	localparam int DIV_CNT_W = $clog2(ID_W);

	localparam int QDEPTH = 2;
	localparam int QPW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCW    = $clog2(QDEPTH + 1);

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	localparam logic OP_ASSIGN  = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef enum logic [1:0] {
		K_ASSIGN  = 2'd0,
		K_RELEASE = 2'd1,
		K_IGNORE  = 2'd2
	} kind_t;

	// one classified item handed from front to back
	typedef struct packed {
		kind_t           kind;
		logic [WIDX-1:0] idx;
		logic [NW-1:0]   n;
	} entry_t;

endpackage

FILE: hdl/least_loaded_session_assigner.sv
// top level of the least-loaded session assigner
//
// usage:
//   input channel (in_valid/in_ready) takes one item: operation 0 assigns
//   session_id to a worker, operation 1 releases one session from
//   released_worker. every item gives exactly one result on the output
//   channel (out_valid/out_ready): chosen_worker, load_after, ignored.
//   cfg_valid/cfg_ready writes active_workers; cfg_ready is always high,
//   write it only while no item is in flight.
// flow:
//   an assign passes the front remainder unit (one id bit a cycle) and then
//   the back scan over the n active workers, n the active worker count. a
//   release skips the division; an ignored one also skips the scan. front
//   and back overlap through a two-entry queue; the front takes a new item
//   only after its last one has been handed to the queue.
// reset: all worker counts clear to zero, active_workers returns to 1,
//   the queue and the result register empty.
// output stall:
//   the result waits in its register; the back end holds its next item and
//   the front keeps accepting until the queue fills.
module least_loaded_session_assigner (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [llsa_pkg::ACTIVE_W-1:0]  active_workers,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           operation,
	input  logic [llsa_pkg::ID_W-1:0]      session_id,
	input  logic [llsa_pkg::RELEASE_W-1:0] released_worker,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [llsa_pkg::CHOSEN_W-1:0]  chosen_worker,
	output logic [llsa_pkg::LOAD_W-1:0]    load_after,
	output logic                           ignored
);

	// configuration register, reset to a single active worker
	logic [llsa_pkg::ACTIVE_W-1:0] active_q;

	// front to queue
	logic             push_valid;
	logic             push_ready;
	llsa_pkg::entry_t push_data;

	// queue to back
	logic             pop_valid;
	logic             pop_ready;
	llsa_pkg::entry_t pop_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= llsa_pkg::ACTIVE_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			active_q <= active_workers;
		end
	end

	// hashing and start-index reduction
	llsa_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.active_workers  (active_q),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.operation       (operation),
		.session_id      (session_id),
		.released_worker (released_worker),
		.push_valid      (push_valid),
		.push_ready      (push_ready),
		.push_data       (push_data)
	);

	// decouples the remainder unit from the scan
	llsa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// counts, scan, update and result register
	llsa_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.pop_valid     (pop_valid),
		.pop_ready     (pop_ready),
		.pop_data      (pop_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.chosen_worker (chosen_worker),
		.load_after    (load_after),
		.ignored       (ignored)
	);

endmodule

FILE: hdl/llsa_queue.sv
// short fifo of classified items between front and back
module llsa_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  llsa_pkg::entry_t push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output llsa_pkg::entry_t pop_data
);

	llsa_pkg::entry_t           slot_q [llsa_pkg::QDEPTH];
	logic [llsa_pkg::QPW-1:0]   wr_ptr_q;
	logic [llsa_pkg::QPW-1:0]   rd_ptr_q;
	logic [llsa_pkg::QCW-1:0]   fill_q;
	logic                       do_push;
	logic                       do_pop;

	assign push_ready = (fill_q != llsa_pkg::QCW'(llsa_pkg::QDEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	function automatic logic [llsa_pkg::QPW-1:0] next_ptr(input logic [llsa_pkg::QPW-1:0] p);
		next_ptr = (p == llsa_pkg::QPW'(llsa_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (do_pop) rd_ptr_q <= next_ptr(rd_ptr_q);
			if (do_push && !do_pop) fill_q <= fill_q + 1'b1;
			else if (do_pop && !do_push) fill_q <= fill_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_data;
	end

endmodule

FILE: hdl/llsa_front.sv
// front end: accepts items, hashes ids and reduces them modulo the worker count
module llsa_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [llsa_pkg::ACTIVE_W-1:0]   active_workers,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            operation,
	input  logic [llsa_pkg::ID_W-1:0]       session_id,
	input  logic [llsa_pkg::RELEASE_W-1:0]  released_worker,
	output logic                            push_valid,
	input  logic                            push_ready,
	output llsa_pkg::entry_t                push_data
);

	typedef enum logic [1:0] {
		F_IDLE = 2'b01,
		F_DIV  = 2'b10
	} front_state_t;

	front_state_t                     st_q;
	logic                             pend_q;
	logic [llsa_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic [llsa_pkg::ID_W-1:0]        div_q;
	logic [llsa_pkg::NW-1:0]          rem_q;
	logic [llsa_pkg::NW-1:0]          n_q;
	llsa_pkg::entry_t                 entry_q;

	logic                             accept;
	logic                             last_bit;
	logic [llsa_pkg::ID_W-1:0]        mixed;
	logic [llsa_pkg::NW-1:0]          n_eff;
	logic [llsa_pkg::NW:0]            trial;
	logic [llsa_pkg::NW-1:0]          rem_next;
	logic                             out_of_range;

	assign in_ready   = (st_q == F_IDLE) && !pend_q;
	assign accept     = in_valid && in_ready;
	assign push_valid = pend_q;
	assign push_data  = entry_q;
	assign last_bit   = (cnt_q == llsa_pkg::DIV_CNT_W'(llsa_pkg::ID_W - 1));

	assign mixed = session_id ^ (session_id >> llsa_pkg::MIX_RIGHT)
		^ (session_id << llsa_pkg::MIX_LEFT);

	assign out_of_range = ({24'b0, released_worker} >= llsa_pkg::NUM_WORKERS);

	// clamp the register to 1..NUM_WORKERS
	always_comb begin
		if (active_workers == '0) begin
			n_eff = llsa_pkg::NW'(1);
		end else if ({27'b0, active_workers} > llsa_pkg::NUM_WORKERS) begin
			n_eff = llsa_pkg::NW'(llsa_pkg::NUM_WORKERS);
		end else begin
			n_eff = llsa_pkg::NW'(active_workers);
		end
	end

	// restoring remainder step, one dividend bit per cycle
	always_comb begin
		trial = {rem_q, div_q[llsa_pkg::ID_W-1]};
		if (trial >= {1'b0, n_q}) begin
			rem_next = llsa_pkg::NW'(trial - {1'b0, n_q});
		end else begin
			rem_next = trial[llsa_pkg::NW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= F_IDLE;
			pend_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (pend_q && push_ready) pend_q <= 1'b0;
			unique case (st_q)
				F_IDLE: begin
					if (accept) begin
						if (operation == llsa_pkg::OP_ASSIGN) begin
							cnt_q <= '0;
							st_q  <= F_DIV;
						end else begin
							pend_q <= 1'b1;
						end
					end
				end
				F_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_bit) begin
						pend_q <= 1'b1;
						st_q   <= F_IDLE;
					end
				end
				default: st_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			div_q <= mixed;
			rem_q <= '0;
			n_q   <= n_eff;
			if (operation == llsa_pkg::OP_RELEASE) begin
				entry_q.n <= n_eff;
				if (out_of_range) begin
					entry_q.kind <= llsa_pkg::K_IGNORE;
					entry_q.idx  <= '0;
				end else begin
					entry_q.kind <= llsa_pkg::K_RELEASE;
					entry_q.idx  <= llsa_pkg::WIDX'(released_worker);
				end
			end
		end else if (st_q == F_DIV) begin
			div_q <= div_q << 1;
			rem_q <= rem_next;
			if (last_bit) begin
				entry_q.kind <= llsa_pkg::K_ASSIGN;
				entry_q.idx  <= llsa_pkg::WIDX'(rem_next);
				entry_q.n    <= n_q;
			end
		end
	end

endmodule

FILE: hdl/llsa_back.sv
// back end: per-worker counts, rotating least-loaded scan and result register
`include "least_loaded_session_assigner_macros.svh"

module llsa_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pop_valid,
	output logic                           pop_ready,
	input  llsa_pkg::entry_t               pop_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [llsa_pkg::CHOSEN_W-1:0]  chosen_worker,
	output logic [llsa_pkg::LOAD_W-1:0]    load_after,
	output logic                           ignored
);

	typedef enum logic [2:0] {
		B_IDLE  = 3'b001,
		B_SCAN  = 3'b010,
		B_WRITE = 3'b100
	} back_state_t;

	back_state_t                        st_q;
	logic [llsa_pkg::COUNT_WIDTH-1:0]   cnt_q [llsa_pkg::NUM_WORKERS];
	llsa_pkg::kind_t                    kind_q;
	logic [llsa_pkg::NW-1:0]            n_q;
	logic [llsa_pkg::NW-1:0]            k_q;
	logic [llsa_pkg::WIDX-1:0]          cand_q;
	logic [llsa_pkg::WIDX-1:0]          best_q;
	logic [llsa_pkg::COUNT_WIDTH-1:0]   best_cnt_q;
	logic                               out_valid_q;
	logic [llsa_pkg::CHOSEN_W-1:0]      chosen_q;
	logic [llsa_pkg::LOAD_W-1:0]        load_q;
	logic                               ignored_q;

	logic                               take_in;
	logic                               out_free;
	logic [llsa_pkg::COUNT_WIDTH-1:0]   rd_cnt;
	logic                               better;
	logic                               last_step;
	logic [llsa_pkg::NW-1:0]            cand_inc;
	logic [llsa_pkg::COUNT_WIDTH-1:0]   new_cnt;
	logic                               finish;

	assign pop_ready     = (st_q == B_IDLE);
	assign take_in       = pop_valid && pop_ready;
	assign out_free      = !out_valid_q || out_ready;
	assign finish        = (st_q == B_WRITE) && out_free;
	assign out_valid     = out_valid_q;
	assign chosen_worker = chosen_q;
	assign load_after    = load_q;
	assign ignored       = ignored_q;

	assign rd_cnt    = cnt_q[cand_q];
	assign better    = (k_q == '0) || (rd_cnt < best_cnt_q);
	assign last_step = (kind_q != llsa_pkg::K_ASSIGN) || (k_q == n_q - 1'b1);
	assign cand_inc  = llsa_pkg::NW'(cand_q) + 1'b1;

	always_comb begin
		unique case (kind_q)
			llsa_pkg::K_ASSIGN:
				new_cnt = (best_cnt_q == llsa_pkg::COUNT_MAX) ? best_cnt_q : best_cnt_q + 1'b1;
			llsa_pkg::K_RELEASE:
				new_cnt = (best_cnt_q == '0) ? best_cnt_q : best_cnt_q - 1'b1;
			default: new_cnt = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= B_IDLE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < llsa_pkg::NUM_WORKERS; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			// a new result replaces the one leaving in the same cycle
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				B_IDLE: begin
					if (take_in) begin
						st_q <= (pop_data.kind == llsa_pkg::K_IGNORE) ? B_WRITE : B_SCAN;
					end
				end
				B_SCAN: begin
					if (last_step) st_q <= B_WRITE;
				end
				B_WRITE: begin
					if (out_free) begin
						if (kind_q != llsa_pkg::K_IGNORE) cnt_q[best_q] <= new_cnt;
						st_q <= B_IDLE;
					end
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			kind_q     <= pop_data.kind;
			n_q        <= pop_data.n;
			cand_q     <= pop_data.idx;
			best_q     <= pop_data.idx;
			best_cnt_q <= '0;
			k_q        <= '0;
		end else if (st_q == B_SCAN) begin
			if (better) begin
				best_q     <= cand_q;
				best_cnt_q <= rd_cnt;
			end
			k_q    <= k_q + 1'b1;
			cand_q <= (cand_inc == n_q) ? '0 : llsa_pkg::WIDX'(cand_inc);
		end
		if (finish) begin
			chosen_q  <= llsa_pkg::CHOSEN_W'(best_q);
			load_q    <= llsa_pkg::LOAD_W'(new_cnt);
			ignored_q <= (kind_q == llsa_pkg::K_IGNORE);
		end
	end

	`LLSA_ASSERT_NOW(a_scan_in_range, (st_q == B_SCAN) && (kind_q == llsa_pkg::K_ASSIGN), (llsa_pkg::NW'(cand_q) < n_q) && (k_q < n_q), "scan left the active worker range")
	`LLSA_ASSERT_NOW(a_ignore_no_scan, st_q == B_SCAN, kind_q != llsa_pkg::K_IGNORE, "ignored release entered the scan")
	`LLSA_ASSERT_NEXT(a_write_shows_result, finish, out_valid_q && (st_q == B_IDLE), "finished item did not reach the result register")

endmodule
